/* design/rsh_pkg.sv */
// Shared constants and types for the ray/sphere hit shader.
`timescale 1ns / 1ps

package rsh_pkg;

  // Register field widths
  localparam int ORIG_W = 19;
  localparam int FOC_W = 18;
  localparam int OFS_W = 19;
  localparam int RAD_W = 18;
  localparam int CFG_DATA_W = 19;
  localparam int CFG_IDX_W = 3;

  // Sun direction, scaled by 10^6
  localparam int SUN_W = 21;
  localparam logic signed [SUN_W-1:0] SUN_X = -21'sd588348;
  localparam logic signed [SUN_W-1:0] SUN_Y = 21'sd196116;
  localparam logic signed [SUN_W-1:0] SUN_Z = -21'sd784460;

  // Width of one partial-product slice in the pipelined multipliers
  localparam int MUL_CHUNK = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Z_ORIGIN = 3'd1,
    CFG_FOCAL    = 3'd2,
    CFG_OFS_X    = 3'd3,
    CFG_OFS_Y    = 3'd4,
    CFG_OFS_Z    = 3'd5,
    CFG_RADIUS   = 3'd6
  } cfg_idx_e;

endpackage

/* design/rsh_delay.sv */
// Enable-gated register delay line.
`timescale 1ns / 1ps

module rsh_delay #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] stage_q [D];

  // shift on every enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) stage_q[i] <= '0;
    end else if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < D; i++) stage_q[i] <= stage_q[i-1];
    end
  end

  assign q_o = stage_q[D-1];

endmodule

/* design/rsh_mul.sv */
// Two-stage signed multiplier, B operand split into slices.
`timescale 1ns / 1ps

module rsh_mul #(
  parameter int AW = 20,
  parameter int BW = 20,
  parameter int CW = 24
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NCH = (BW + CW - 1) / CW;
  localparam int PPW = AW + CW + 1;
  localparam int SUMW = AW + NCH * CW + 1;

  logic signed [NCH*CW-1:0] bx;
  logic signed [PPW-1:0]    pp_d [NCH];
  logic signed [PPW-1:0]    pp_q [NCH];
  logic signed [SUMW-1:0]   acc;
  logic signed [AW+BW-1:0]  p_q;

  assign bx = (NCH*CW)'(b_i);

  // partial products: low slices unsigned, top slice signed
  always_comb begin
    for (int j = 0; j < NCH; j++) begin
      if (j == NCH - 1) begin
        pp_d[j] = PPW'(a_i * $signed(bx[j*CW +: CW]));
      end else begin
        pp_d[j] = PPW'(a_i * $signed({1'b0, bx[j*CW +: CW]}));
      end
    end
  end

  // recombine slices
  always_comb begin
    acc = '0;
    for (int j = 0; j < NCH; j++) begin
      acc = acc + (SUMW'(pp_q[j]) <<< (j * CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
      p_q  <= acc[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

/* design/rsh_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps

module rsh_isqrt #(
  parameter int SW = 44
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*SW-1:0] x_i,
  output logic [SW-1:0]   root_o
);

  localparam int RMW = SW + 2;

  logic [RMW-1:0]  rem_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [2*SW-1:0] qs_q   [SW-1];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RMW-1:0]  rem_in;
    logic [SW-1:0]   root_in;
    logic [2*SW-1:0] qs_in;
    logic [RMW+1:0]  r2;
    logic [RMW+1:0]  trial;
    logic [RMW+1:0]  diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign qs_in   = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign qs_in   = qs_q[k-1];
    end

    // bring down two radicand bits and try root*4+1
    assign r2    = {rem_in, qs_in[2*SW-1 -: 2]};
    assign trial = (RMW+2)'({root_in, 2'b01});
    assign diff  = r2 - trial;
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[RMW-1:0] : r2[RMW-1:0];
        root_q[k] <= {root_in[SW-2:0], ge};
      end
    end

    if (k < SW - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) qs_q[k] <= {qs_in[2*SW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SW-1];

endmodule

/* design/ray_sphere_hit_shader.sv */
// Top level: pipelined ray/sphere hit test with a lit bit per pixel.
//
// Usage: pixels enter on the in_ beat channel (pixel_col_i, pixel_row_i),
// one per cycle while in_ready_o is high. For each pixel whose camera ray
// passes within the sphere radius, one beat leaves on the out_ channel with
// the same column and row and a lit bit; pixels that miss give no beat.
// Order is kept. The floor square root gives one result bit per pipeline
// stage; its width SW is 44 with the default parameters. Throughput is one
// pixel per cycle while the pipeline is not stalled.
// The pipeline advances as a whole. It stalls only when the output
// register holds an untaken beat and the last stage holds a hit; a miss or
// a bubble in the last stage lets it keep moving, so the input stays ready.
// Registers are written on the cfg_ channel (index, data), always ready,
// and may change only while no pixel is in flight.
// Reset clears all valid bits and loads the register defaults; the block
// takes input beats in the first cycle after reset.
`timescale 1ns / 1ps

module ray_sphere_hit_shader #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [COORD_BITS-1:0]          pixel_col_i,
  input  logic [COORD_BITS-1:0]          pixel_row_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COORD_BITS-1:0]          hit_col_o,
  output logic [COORD_BITS-1:0]          hit_row_o,
  output logic                           lit_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rsh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CB  = COORD_BITS;
  localparam int RW  = ((CB + FRAC_BITS + 1 > rsh_pkg::ORIG_W) ?
                        CB + FRAC_BITS + 1 : rsh_pkg::ORIG_W) + 1;
  localparam int AW1 = (RW > rsh_pkg::SUN_W) ? RW : rsh_pkg::SUN_W;
  localparam int BW1 = RW;
  localparam int MW1 = AW1 + BW1;
  localparam int WW  = MW1 + 1;
  localparam int RRW = MW1 + 2;
  localparam int VRW = MW1 + 2;
  localparam int PW  = MW1 + 2;
  localparam int CCW = PW + 1;
  localparam int AW2 = WW;
  localparam int BW2 = RRW;
  localparam int MW2 = AW2 + BW2;
  localparam int XW  = MW2 + 2;
  localparam int TW  = MW2 + 1;
  localparam int QW  = XW + 1;
  localparam int SW  = QW / 2;
  localparam int MW3 = rsh_pkg::SUN_W + TW;
  localparam int AAW = MW3 + 2;
  localparam int MW4 = CCW + SW + 1;
  localparam int TOTW = ((AAW > MW4) ? AAW : MW4) + 1;
  localparam int CW  = rsh_pkg::MUL_CHUNK;

  // ---------------- configuration registers ----------------
  logic signed [rsh_pkg::ORIG_W-1:0] x_origin_q, z_origin_q;
  logic        [rsh_pkg::FOC_W-1:0]  focal_q;
  logic signed [rsh_pkg::OFS_W-1:0]  ofs_x_q, ofs_y_q, ofs_z_q;
  logic        [rsh_pkg::RAD_W-1:0]  radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      z_origin_q <= '0;
      focal_q    <= rsh_pkg::FOC_W'(1280);
      ofs_x_q    <= '0;
      ofs_y_q    <= rsh_pkg::OFS_W'(8960);
      ofs_z_q    <= '0;
      radius_q   <= rsh_pkg::RAD_W'(5120);
    end else if (cfg_valid_i) begin
      case (rsh_pkg::cfg_idx_e'(cfg_index_i))
        rsh_pkg::CFG_X_ORIGIN: x_origin_q <= $signed(cfg_data_i);
        rsh_pkg::CFG_Z_ORIGIN: z_origin_q <= $signed(cfg_data_i);
        rsh_pkg::CFG_FOCAL:    focal_q    <= cfg_data_i[rsh_pkg::FOC_W-1:0];
        rsh_pkg::CFG_OFS_X:    ofs_x_q    <= $signed(cfg_data_i);
        rsh_pkg::CFG_OFS_Y:    ofs_y_q    <= $signed(cfg_data_i);
        rsh_pkg::CFG_OFS_Z:    ofs_z_q    <= $signed(cfg_data_i);
        rsh_pkg::CFG_RADIUS:   radius_q   <= cfg_data_i[rsh_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic out_vld_q;
  logic hit_l, nz_l;
  logic [CB-1:0] col_l, row_l;

  assign en         = !out_vld_q || out_ready_i || !hit_l;
  assign in_ready_o = en;

  // ---------------- S1: ray vector ----------------
  logic              v1_q;
  logic [CB-1:0]     col1_q, row1_q;
  logic signed [RW-1:0] rx1_q, ry1_q, rz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col1_q <= pixel_col_i;
      row1_q <= pixel_row_i;
      rx1_q  <= $signed(RW'({pixel_col_i, {FRAC_BITS{1'b0}}})) - RW'(x_origin_q);
      ry1_q  <= $signed(RW'(focal_q));
      rz1_q  <= $signed(RW'({pixel_row_i, {FRAC_BITS{1'b0}}})) - RW'(z_origin_q);
    end
  end

  // ---------------- S1 -> S3: first product bank ----------------
  logic signed [AW1-1:0] a1 [16];
  logic signed [BW1-1:0] b1 [16];
  logic signed [MW1-1:0] p1 [16];

  always_comb begin
    a1[0]  = AW1'(ofs_y_q);  b1[0]  = rz1_q;
    a1[1]  = AW1'(ofs_z_q);  b1[1]  = ry1_q;
    a1[2]  = AW1'(ofs_z_q);  b1[2]  = rx1_q;
    a1[3]  = AW1'(ofs_x_q);  b1[3]  = rz1_q;
    a1[4]  = AW1'(ofs_x_q);  b1[4]  = ry1_q;
    a1[5]  = AW1'(ofs_y_q);  b1[5]  = rx1_q;
    a1[6]  = AW1'(ofs_x_q);  b1[6]  = rx1_q;
    a1[7]  = AW1'(ofs_y_q);  b1[7]  = ry1_q;
    a1[8]  = AW1'(ofs_z_q);  b1[8]  = rz1_q;
    a1[9]  = AW1'(rx1_q);    b1[9]  = rx1_q;
    a1[10] = AW1'(ry1_q);    b1[10] = ry1_q;
    a1[11] = AW1'(rz1_q);    b1[11] = rz1_q;
    a1[12] = AW1'(rsh_pkg::SUN_X); b1[12] = rx1_q;
    a1[13] = AW1'(rsh_pkg::SUN_Y); b1[13] = ry1_q;
    a1[14] = AW1'(rsh_pkg::SUN_Z); b1[14] = rz1_q;
    a1[15] = $signed(AW1'(radius_q)); b1[15] = $signed(BW1'(radius_q));
  end

  for (genvar k = 0; k < 16; k++) begin : g_mul1
    rsh_mul #(.AW(AW1), .BW(BW1), .CW(CW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (a1[k]),
      .b_i   (b1[k]),
      .p_o   (p1[k])
    );
  end

  // ---------------- S4: w = v x r, |r|^2, v.r, s.r ----------------
  logic signed [WW-1:0]  wx4_q, wy4_q, wz4_q;
  logic signed [RRW-1:0] rr4_q;
  logic signed [VRW-1:0] vr4_q;
  logic signed [PW-1:0]  p4_q;
  logic signed [MW1-1:0] r2_4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx4_q  <= WW'(p1[0]) - WW'(p1[1]);
      wy4_q  <= WW'(p1[2]) - WW'(p1[3]);
      wz4_q  <= WW'(p1[4]) - WW'(p1[5]);
      vr4_q  <= VRW'(p1[6]) + VRW'(p1[7]) + VRW'(p1[8]);
      rr4_q  <= RRW'(p1[9]) + RRW'(p1[10]) + RRW'(p1[11]);
      p4_q   <= PW'(p1[12]) + PW'(p1[13]) + PW'(p1[14]);
      r2_4_q <= p1[15];
    end
  end

  // ray components aligned to S4
  logic [3*RW-1:0] r4_vec;
  logic signed [RW-1:0] rx4, ry4, rz4;

  rsh_delay #(.W(3*RW), .D(3)) u_dly_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({rx1_q, ry1_q, rz1_q}),
    .q_o    (r4_vec)
  );

  assign rx4 = $signed(r4_vec[3*RW-1 -: RW]);
  assign ry4 = $signed(r4_vec[2*RW-1 -: RW]);
  assign rz4 = $signed(r4_vec[RW-1:0]);

  // ---------------- S4 -> S6: second product bank ----------------
  logic signed [AW2-1:0] a2 [10];
  logic signed [BW2-1:0] b2 [10];
  logic signed [MW2-1:0] p2 [10];

  always_comb begin
    a2[0] = wx4_q;           b2[0] = BW2'(wx4_q);
    a2[1] = wy4_q;           b2[1] = BW2'(wy4_q);
    a2[2] = wz4_q;           b2[2] = BW2'(wz4_q);
    a2[3] = AW2'(r2_4_q);    b2[3] = rr4_q;
    a2[4] = AW2'(ry4);       b2[4] = BW2'(wz4_q);
    a2[5] = AW2'(rz4);       b2[5] = BW2'(wy4_q);
    a2[6] = AW2'(rz4);       b2[6] = BW2'(wx4_q);
    a2[7] = AW2'(rx4);       b2[7] = BW2'(wz4_q);
    a2[8] = AW2'(rx4);       b2[8] = BW2'(wy4_q);
    a2[9] = AW2'(ry4);       b2[9] = BW2'(wx4_q);
  end

  for (genvar k = 0; k < 10; k++) begin : g_mul2
    rsh_mul #(.AW(AW2), .BW(BW2), .CW(CW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (a2[k]),
      .b_i   (b2[k]),
      .p_o   (p2[k])
    );
  end

  // side flags from S4: zero ray, centre perpendicular to ray
  logic [1:0] flg7;
  logic       zr7, vrnz7;

  rsh_delay #(.W(2), .D(3)) u_dly_flg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({rr4_q == '0, vr4_q != '0}),
    .q_o    (flg7)
  );

  assign zr7   = flg7[1];
  assign vrnz7 = flg7[0];

  // signed projection term, sign follows v.r; aligned to the root
  logic signed [CCW-1:0] c_d;
  logic [CCW-1:0]        c_l;

  assign c_d = (vr4_q > 0) ? CCW'(p4_q) : -CCW'(p4_q);

  rsh_delay #(.W(CCW), .D(SW + 4)) u_dly_c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (c_d),
    .q_o    (c_l)
  );

  // ---------------- S7: |v x r|^2, R^2|r|^2, t = r x w ----------------
  logic signed [XW-1:0]  cross7_q;
  logic signed [MW2-1:0] r2rr7_q;
  logic signed [TW-1:0]  tx7_q, ty7_q, tz7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cross7_q <= XW'(p2[0]) + XW'(p2[1]) + XW'(p2[2]);
      r2rr7_q  <= p2[3];
      tx7_q    <= TW'(p2[4]) - TW'(p2[5]);
      ty7_q    <= TW'(p2[6]) - TW'(p2[7]);
      tz7_q    <= TW'(p2[8]) - TW'(p2[9]);
    end
  end

  // pixel tags from S1 to S7
  logic [2*CB:0] meta7;
  logic          v7;

  rsh_delay #(.W(2*CB + 1), .D(6)) u_dly_meta1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({v1_q, col1_q, row1_q}),
    .q_o    (meta7)
  );

  assign v7 = meta7[2*CB];

  // ---------------- S8: Q and hit test ----------------
  logic signed [QW-1:0] q_d;
  logic signed [QW-1:0] q8_q;
  logic                 hit7;
  logic                 nz7;

  assign q_d  = QW'(r2rr7_q) - QW'(cross7_q);
  assign hit7 = v7 && !zr7 && !q_d[QW-1];
  assign nz7  = vrnz7 && (radius_q != '0);

  always_ff @(posedge clk_i) begin
    if (en) q8_q <= q_d;
  end

  // hit tags from S7 to the last stage
  logic [2*CB+1:0] meta_l;

  rsh_delay #(.W(2*CB + 2), .D(SW + 3)) u_dly_meta2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({meta7[2*CB-1:0], hit7, nz7}),
    .q_o    (meta_l)
  );

  assign col_l = meta_l[2*CB+1 -: CB];
  assign row_l = meta_l[CB+1 -: CB];
  assign hit_l = meta_l[1];
  assign nz_l  = meta_l[0];

  // ---------------- S7 -> S9: sun . t, sum at S10 ----------------
  logic signed [MW3-1:0] p3 [3];
  logic signed [TW-1:0]  b3 [3];
  logic signed [rsh_pkg::SUN_W-1:0] a3 [3];

  always_comb begin
    a3[0] = rsh_pkg::SUN_X; b3[0] = tx7_q;
    a3[1] = rsh_pkg::SUN_Y; b3[1] = ty7_q;
    a3[2] = rsh_pkg::SUN_Z; b3[2] = tz7_q;
  end

  for (genvar k = 0; k < 3; k++) begin : g_mul3
    rsh_mul #(.AW(rsh_pkg::SUN_W), .BW(TW), .CW(CW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (a3[k]),
      .b_i   (b3[k]),
      .p_o   (p3[k])
    );
  end

  logic signed [AAW-1:0] a10_q;
  logic [AAW-1:0]        a_l;

  always_ff @(posedge clk_i) begin
    if (en) a10_q <= AAW'(p3[0]) + AAW'(p3[1]) + AAW'(p3[2]);
  end

  rsh_delay #(.W(AAW), .D(SW)) u_dly_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (a10_q),
    .q_o    (a_l)
  );

  // ---------------- S8 -> S8+SW: floor sqrt(Q) ----------------
  logic [SW-1:0] root;

  rsh_isqrt #(.SW(SW)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    ((2*SW)'(q8_q[QW-2:0])),
    .root_o (root)
  );

  // ---------------- last stage: c * root ----------------
  logic signed [MW4-1:0] prod_l;

  rsh_mul #(.AW(CCW), .BW(SW + 1), .CW(CW)) u_mul4 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ($signed(c_l)),
    .b_i   ($signed({1'b0, root})),
    .p_o   (prod_l)
  );

  // lit when the normal is defined and the scaled -sun.n is positive, i.e. the total is negative
  logic signed [TOTW-1:0] total;
  logic                   lit_d;

  assign total = TOTW'($signed(a_l)) + TOTW'(prod_l);
  assign lit_d = nz_l && total[TOTW-1];

  // ---------------- output register ----------------
  logic [CB-1:0] hit_col_q, hit_row_q;
  logic          lit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en && hit_l) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && hit_l) begin
      hit_col_q <= col_l;
      hit_row_q <= row_l;
      lit_q     <= lit_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_col_o   = hit_col_q;
  assign hit_row_o   = hit_row_q;
  assign lit_o       = lit_q;

  // ---------------- assertions ----------------
  // input back-pressure only comes from a held output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held output beat");

  // a hit in the last stage waits while the pipeline is frozen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_l && !en) |=> (hit_l && $stable(col_l) && $stable(row_l)))
    else $error("stalled hit lost or changed");

  // a loaded beat is lit only when its normal is defined
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && hit_l && !nz_l) |=> !lit_o)
    else $error("lit set on degenerate normal");

  // a beat never loads over an untaken one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i && hit_l) |-> !en)
    else $error("output beat overwritten");

endmodule

/* verif/ray_sphere_hit_shader_tb.sv */
// Self-checking testbench for the ray/sphere hit shader.
`timescale 1ns / 1ps

module ray_sphere_hit_shader_tb;

  typedef logic signed [127:0] wide_t;

  localparam int LATENCY = 55;
  localparam int SETTLE = 2 * LATENCY;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [rsh_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [rsh_pkg::CFG_IDX_W-1:0] idx;
    logic [rsh_pkg::CFG_DATA_W-1:0] data;
    logic [9:0] col;
    logic [9:0] row;
    logic typed;
    logic hit;
    logic lit;
  } stim_row_t;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic lit;
  } hit_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i, out_ready_i, cfg_valid_i;
  logic in_ready_o, out_valid_o, cfg_ready_o, lit_o;
  logic [9:0] pixel_col_i, pixel_row_i, hit_col_o, hit_row_o;
  logic [rsh_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [rsh_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the camera and sphere registers
  wide_t x_orig, z_orig, focal, ofs_x, ofs_y, ofs_z, radius;

  hit_beat_t hits_pending[$];
  int mismatches = 0;
  int cycles = 0;
  int in_idle = 0;
  int out_idle = 0;

  ray_sphere_hit_shader u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .pixel_col_i(pixel_col_i), .pixel_row_i(pixel_row_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .hit_col_o(hit_col_o), .hit_row_o(hit_row_o), .lit_o(lit_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle);
  end

  function automatic void reset_camera();
    x_orig = 0; z_orig = 0; focal = 1280;
    ofs_x = 0; ofs_y = 8960; ofs_z = 0; radius = 5120;
  endfunction

  function automatic void apply_cfg(logic [rsh_pkg::CFG_IDX_W-1:0] idx,
                                    logic [rsh_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      rsh_pkg::CFG_X_ORIGIN: x_orig = wide_t'($signed(d));
      rsh_pkg::CFG_Z_ORIGIN: z_orig = wide_t'($signed(d));
      rsh_pkg::CFG_FOCAL:    focal = wide_t'(d[rsh_pkg::FOC_W-1:0]);
      rsh_pkg::CFG_OFS_X:    ofs_x = wide_t'($signed(d));
      rsh_pkg::CFG_OFS_Y:    ofs_y = wide_t'($signed(d));
      rsh_pkg::CFG_OFS_Z:    ofs_z = wide_t'($signed(d));
      rsh_pkg::CFG_RADIUS:   radius = wide_t'(d[rsh_pkg::RAD_W-1:0]);
      default: ;
    endcase
  endfunction

  // Exact hit test and lit decision on n * |r|^2, all in 128-bit integers
  function automatic void shade_pixel(input logic [9:0] col, input logic [9:0] row,
                                      output logic hit, output logic lit);
    wide_t rx, ry, rz, wx, wy, wz, cross2, rr, q, vr;
    wide_t tx, ty, tz, a, p, c, root, y, total;
    rx = (wide_t'(col) <<< 8) - x_orig;
    ry = focal;
    rz = (wide_t'(row) <<< 8) - z_orig;
    hit = 1'b0;
    lit = 1'b0;
    if (rx == 0 && ry == 0 && rz == 0) return;
    wx = ofs_y * rz - ofs_z * ry;
    wy = ofs_z * rx - ofs_x * rz;
    wz = ofs_x * ry - ofs_y * rx;
    cross2 = wx * wx + wy * wy + wz * wz;
    rr = rx * rx + ry * ry + rz * rz;
    q = radius * radius * rr - cross2;
    if (q < 0) return;
    hit = 1'b1;
    vr = ofs_x * rx + ofs_y * ry + ofs_z * rz;
    if (radius == 0 || vr == 0) return;
    tx = ry * wz - rz * wy;
    ty = rz * wx - rx * wz;
    tz = rx * wy - ry * wx;
    a = wide_t'(rsh_pkg::SUN_X) * tx + wide_t'(rsh_pkg::SUN_Y) * ty +
        wide_t'(rsh_pkg::SUN_Z) * tz;
    p = wide_t'(rsh_pkg::SUN_X) * rx + wide_t'(rsh_pkg::SUN_Y) * ry +
        wide_t'(rsh_pkg::SUN_Z) * rz;
    c = (vr > 0) ? p : -p;
    root = 0;
    for (int b = 62; b >= 0; b--) begin
      y = root | (wide_t'(1) <<< b);
      if (y * y <= q) root = y;
    end
    total = a + c * root;
    lit = (total < 0);
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d got %0d", what, want, got);
  endtask

  // Output checker: each hit beat against the oldest pending hit
  always @(posedge clk_i) begin
    hit_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hits_pending.size() == 0) begin
        flag_mismatch("unexpected hit beat, col", -1, hit_col_o);
      end else begin
        want = hits_pending.pop_front();
        if (hit_col_o !== want.col) flag_mismatch("hit_col", want.col, hit_col_o);
        if (hit_row_o !== want.row) flag_mismatch("hit_row", want.row, hit_row_o);
        if (lit_o !== want.lit) flag_mismatch("lit", want.lit, lit_o);
      end
    end
  end

  // One pixel beat; typed rows bypass the predictor
  task automatic send_pixel(logic [9:0] col, logic [9:0] row,
                            logic typed = 1'b0, logic t_hit = 1'b0, logic t_lit = 1'b0);
    logic hit, lit;
    if ($urandom_range(99) < in_idle) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < in_idle);
    end
    in_valid_i <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) begin
      hit = t_hit;
      lit = t_lit;
    end else begin
      shade_pixel(col, row, hit, lit);
    end
    if (hit) hits_pending.push_back('{col: col, row: row, lit: lit});
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every pending hit, then let misses flush out
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (hits_pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [rsh_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsh_pkg::CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [rsh_pkg::CFG_DATA_W-1:0] pick_signed();
    case ($urandom_range(5))
      0: return 19'h40000;
      1: return 19'h3FFFF;
      2: return 19'h0;
      default: return 19'($urandom);
    endcase
  endfunction

  function automatic logic [rsh_pkg::CFG_DATA_W-1:0] pick_unsigned();
    case ($urandom_range(5))
      0: return 19'd0;
      1: return 19'h3FFFF;
      default: return {1'b0, 18'($urandom)};
    endcase
  endfunction

  // Directed rows: reset view, extremes, zero ray, zero radius,
  // sphere behind the camera, centre perpendicular to the ray
  stim_row_t directed[] = '{
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd2, 10'd1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd3, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_RADIUS, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_FOCAL, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd1, 10'd0, 1'b1, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_RADIUS, 19'h3FFFF, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_X_ORIGIN, 19'h3FFFF, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_Z_ORIGIN, 19'h40000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd1023, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd512, 10'd512, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_FOCAL, 19'h3FFFF, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_X, 19'h40000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_Y, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_Z, 19'h3FFFF, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_UNUSED_IDX, 19'h7FFFF, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd5, 10'd5, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_X_ORIGIN, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_Z_ORIGIN, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_FOCAL, 19'd1280, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_X, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_Z, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_RADIUS, 19'd5120, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_Y, 19'h40000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd0, 1'b1, 1'b1, 1'b1},
    '{ROW_CFG, rsh_pkg::CFG_OFS_Y, 19'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, rsh_pkg::CFG_OFS_X, 19'd5120, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIX, 3'd0, 19'd0, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0}
  };

  initial begin
    int span, ctr_c, ctr_r, sph_dist, rad_px;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    reset_camera();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, registers only touched with the pipe empty
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i].col, directed[i].row,
                   directed[i].typed, directed[i].hit, directed[i].lit);
      end
    end

    // Random phases: idling mode cycles, camera alternates between a
    // sphere aimed near the screen centre and fully random registers
    for (int ph = 0; ph < 9; ph++) begin
      drain_pipe();
      case (ph % 3)
        0: begin in_idle = 9; out_idle = 73; end
        1: begin in_idle = 73; out_idle = 9; end
        default: begin in_idle = 0; out_idle = 0; end
      endcase
      if (ph % 2 == 0) begin
        sph_dist = $urandom_range(2048, 200000);
        write_reg(rsh_pkg::CFG_X_ORIGIN,
                  19'((512 << 8) + $signed($urandom_range(8192)) - 4096));
        write_reg(rsh_pkg::CFG_Z_ORIGIN,
                  19'((512 << 8) + $signed($urandom_range(8192)) - 4096));
        write_reg(rsh_pkg::CFG_FOCAL, 19'($urandom_range(256, 65536)));
        write_reg(rsh_pkg::CFG_OFS_X, 19'($signed($urandom_range(8192)) - 4096));
        write_reg(rsh_pkg::CFG_OFS_Y,
                  19'(($urandom_range(3) == 0) ? -sph_dist : sph_dist));
        write_reg(rsh_pkg::CFG_OFS_Z, 19'($signed($urandom_range(8192)) - 4096));
        write_reg(rsh_pkg::CFG_RADIUS, 19'($urandom_range(0, sph_dist)));
      end else begin
        write_reg(rsh_pkg::CFG_X_ORIGIN, pick_signed());
        write_reg(rsh_pkg::CFG_Z_ORIGIN, pick_signed());
        write_reg(rsh_pkg::CFG_FOCAL, pick_unsigned());
        write_reg(rsh_pkg::CFG_OFS_X, pick_signed());
        write_reg(rsh_pkg::CFG_OFS_Y, pick_signed());
        write_reg(rsh_pkg::CFG_OFS_Z, pick_signed());
        write_reg(rsh_pkg::CFG_RADIUS, pick_unsigned());
      end
      // Projected spot of the sphere on screen, rough
      ctr_c = 512 - (int'(x_orig) >>> 8) + 512;
      ctr_r = 512 - (int'(z_orig) >>> 8) + 512;
      if (ofs_y != 0) begin
        ctr_c = (int'(x_orig) + int'(ofs_x * focal / ofs_y)) >>> 8;
        ctr_r = (int'(z_orig) + int'(ofs_z * focal / ofs_y)) >>> 8;
        rad_px = int'((radius * focal / (ofs_y < 0 ? -ofs_y : ofs_y)) >>> 8);
      end else begin
        rad_px = 511;
      end
      span = (rad_px > 255) ? 511 : 2 * rad_px + 4;
      for (int n = 0; n < 220; n++) begin
        if (n == 110) drain_pipe();
        if ($urandom_range(4) == 0) begin
          send_pixel(10'($urandom), 10'($urandom));
        end else begin
          send_pixel(10'(ctr_c + $signed($urandom_range(2 * span)) - span),
                     10'(ctr_r + $signed($urandom_range(2 * span)) - span));
        end
      end
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
